// ===== rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg: shared constants and types for the primality test block
// Verdict codes and default operand width.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    localparam int DEFAULT_NUM_BITS = 31;
    localparam int FIELD_W          = 31;

    typedef enum logic [1:0] {
        VERDICT_COMPOSITE = 2'd0,
        VERDICT_PRIME     = 2'd1,
        VERDICT_BAD_WIT   = 2'd2
    } verdict_t;

endpackage

`default_nettype wire

// ===== rtl/solovay_strassen_prime_test.sv =====
// ----------------------------------------------------------------------------
// solovay_strassen_prime_test
// One Solovay-Strassen round per input transfer; verdict on the last round.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tdata = {last_round? no} -> candidate [30:0], witness [61:31];
//           tlast = last_round. One round per transfer.
//   m_axis: tdata[1:0] = verdict, one transfer per round marked tlast.
// Each round runs a^((n-1)/2) mod n by square-and-multiply, where each modular
// multiply is a shift-add loop over a small modular add/double unit (one bit
// of the multiplier per cycle), followed by a Jacobi loop
// (each step is a halving or a swap and reduce; the reduction a mod n is a
// restoring subtract, one quotient bit per cycle).
// Trivial candidates (below 2, 2, 3 or even) and out-of-range witnesses skip
// the power and Jacobi loops.
// s_axis_tready is low while a round is in progress and while a verdict waits
// in the output register; a stalled receiver holds the block in that state.
// After reset the pass flag is set, the error flag clear, and no verdict is
// pending.
// ----------------------------------------------------------------------------
`default_nettype none

module solovay_strassen_prime_test
    import ssp_pkg::*;
#(
    parameter int NUM_BITS = DEFAULT_NUM_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [30:0] candidate, [61:31] witness
    input  wire logic        s_axis_tlast,  // last_round
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [1:0] verdict
);

    localparam int W  = NUM_BITS;
    localparam int CW = $clog2(NUM_BITS + 1) + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PW_BIT, ST_MUL, ST_JA_CHK, ST_JA_HALF, ST_JA_SWAP,
        ST_MOD_INIT, ST_MOD, ST_DONE, ST_OUT
    } state_t;

    state_t         state_reg;
    logic [W-1:0]   n_reg;      // modulus
    logic [W-1:0]   e_reg;      // remaining exponent
    logic [W-1:0]   r_reg;      // power result
    logic [W-1:0]   b_reg;      // power base
    logic [W-1:0]   mx_reg;     // multiplicand (doubling)
    logic [W-1:0]   my_reg;     // multiplier (shifting)
    logic [W-1:0]   acc_reg;    // product accumulator
    logic           msq_reg;    // 0: r*b, 1: b*b
    logic [W-1:0]   ja_reg, jn_reg, wit_reg;
    logic           js_reg;     // 1 means sign is -1
    logic [W-1:0]   rem_reg, dsh_reg;
    logic [CW-1:0]  cnt_reg;
    logic           last_reg, pass_reg, bad_reg;
    logic [1:0]     verdict_reg;

    logic [W-1:0]   cand, wit;
    assign cand = W'(s_axis_tdata[FIELD_W-1:0]);
    assign wit  = W'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);

    // doubling of mx, reduced mod n
    logic [W:0]   dbl_sum;
    logic [W-1:0] dbl_res;
    assign dbl_sum = {mx_reg, 1'b0};
    assign dbl_res = (dbl_sum >= {1'b0, n_reg}) ? dbl_sum[W-1:0] - n_reg : dbl_sum[W-1:0];

    logic [W-1:0] acc_add;
    logic [W:0]   acc_sum;
    assign acc_sum = {1'b0, acc_reg} + {1'b0, mx_reg};
    assign acc_add = (acc_sum >= {1'b0, n_reg}) ? acc_sum[W-1:0] - n_reg : acc_sum[W-1:0];

    logic [W-1:0] nm1;
    assign nm1 = n_reg - W'(1);

    logic [W:0] dsh_dbl;
    assign dsh_dbl = {dsh_reg, 1'b0};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {6'd0, verdict_reg};

    logic [2:0] n8;
    assign n8 = jn_reg[2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b1;
            bad_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        last_reg <= s_axis_tlast;
                        n_reg    <= cand;
                        wit_reg  <= wit;
                        state_reg <= ST_DONE;
                        if (cand == W'(2) || cand == W'(3)) begin
                        end else if (cand < W'(2) || cand[0] == 1'b0) begin
                            pass_reg <= 1'b0;
                        end else if (wit < W'(2) || wit > cand - W'(2)) begin
                            bad_reg <= 1'b1;
                        end else begin
                            e_reg     <= cand >> 1;
                            r_reg     <= W'(1);
                            b_reg     <= wit;
                            state_reg <= ST_PW_BIT;
                        end
                    end
                end
                ST_PW_BIT: begin
                    acc_reg <= '0;
                    if (e_reg == '0) begin
                        ja_reg    <= wit_reg;
                        jn_reg    <= n_reg;
                        js_reg    <= 1'b0;
                        state_reg <= ST_JA_CHK;
                    end else if (e_reg[0]) begin
                        msq_reg   <= 1'b0;
                        mx_reg    <= r_reg;
                        my_reg    <= b_reg;
                        state_reg <= ST_MUL;
                    end else begin
                        msq_reg   <= 1'b1;
                        mx_reg    <= b_reg;
                        my_reg    <= b_reg;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (my_reg == '0) begin
                        if (msq_reg) begin
                            b_reg     <= acc_reg;
                            e_reg     <= e_reg >> 1;
                            state_reg <= ST_PW_BIT;
                        end else begin
                            r_reg   <= acc_reg;
                            msq_reg <= 1'b1;
                            mx_reg  <= b_reg;
                            my_reg  <= b_reg;
                            acc_reg <= '0;
                        end
                    end else begin
                        if (my_reg[0]) begin
                            acc_reg <= acc_add;
                        end
                        mx_reg <= dbl_res;
                        my_reg <= my_reg >> 1;
                    end
                end
                ST_JA_CHK: begin
                    if (ja_reg == '0) begin
                        if (jn_reg != W'(1)) begin
                            pass_reg <= 1'b0;
                        end else if (r_reg != (js_reg ? nm1 : W'(1))) begin
                            pass_reg <= 1'b0;
                        end
                        state_reg <= ST_DONE;
                    end else if (ja_reg[0] == 1'b0) begin
                        state_reg <= ST_JA_HALF;
                    end else begin
                        state_reg <= ST_JA_SWAP;
                    end
                end
                ST_JA_HALF: begin
                    ja_reg <= ja_reg >> 1;
                    if (n8 == 3'd3 || n8 == 3'd5) begin
                        js_reg <= ~js_reg;
                    end
                    state_reg <= ST_JA_CHK;
                end
                ST_JA_SWAP: begin
                    ja_reg <= jn_reg;
                    jn_reg <= ja_reg;
                    if (ja_reg[1:0] == 2'b11 && jn_reg[1:0] == 2'b11) begin
                        js_reg <= ~js_reg;
                    end
                    state_reg <= ST_MOD_INIT;
                end
                ST_MOD_INIT: begin
                    // align divisor jn under remainder ja
                    rem_reg <= ja_reg;
                    dsh_reg <= jn_reg;
                    cnt_reg <= '0;
                    state_reg <= ST_MOD;
                end
                ST_MOD: begin
                    // grow divisor until above remainder, then subtract back down
                    if (dsh_dbl <= {1'b0, rem_reg} && cnt_reg[CW-1] == 1'b0) begin
                        dsh_reg <= dsh_dbl[W-1:0];
                        cnt_reg <= cnt_reg + CW'(1);
                    end else begin
                        cnt_reg[CW-1] <= 1'b1;
                        if (rem_reg >= dsh_reg) begin
                            rem_reg <= rem_reg - dsh_reg;
                        end
                        if (cnt_reg[CW-2:0] == '0) begin
                            ja_reg <= (rem_reg >= dsh_reg) ? rem_reg - dsh_reg : rem_reg;
                            state_reg <= ST_JA_CHK;
                        end else begin
                            dsh_reg <= dsh_reg >> 1;
                            cnt_reg[CW-2:0] <= cnt_reg[CW-2:0] - (CW-1)'(1);
                        end
                    end
                end
                ST_DONE: begin
                    if (last_reg) begin
                        verdict_reg <= bad_reg ? VERDICT_BAD_WIT :
                                       (pass_reg ? VERDICT_PRIME : VERDICT_COMPOSITE);
                        pass_reg  <= 1'b1;
                        bad_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(verdict_reg)))
        else $error("verdict dropped");
    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (verdict_reg != 2'd3))
        else $error("bad verdict code");
    a_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> (pass_reg && !bad_reg))
        else $error("flags not cleared");

endmodule

`default_nettype wire
